FILE: rtl/core/cdwi_pkg.sv
package cdwi_pkg;

  localparam int DEF_MAX_COLS  = 4;
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_MAX_ROWS  = 1048576;
  localparam int DEF_MAX_BATCH = 256;

  localparam int IN_COLS  = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS      = 4'd0,
    REG_BATCH_LEAD    = 4'd1,
    REG_REMAP_NEW     = 4'd2,
    REG_REPORT_STORED = 4'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BATCH_OOR = 2'd2
  } status_t;

endpackage

FILE: rtl/core/cdwi_ifs.sv
interface cdwi_row_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_a;
  logic signed [31:0] coord_b;
  logic signed [31:0] coord_c;
  logic signed [31:0] coord_d;
  logic               start_set;
  logic               last_row;
  modport source (output valid, coord_a, coord_b, coord_c, coord_d, start_set, last_row,
                  input ready);
  modport sink (input valid, coord_a, coord_b, coord_c, coord_d, start_set, last_row,
                output ready);
endinterface

interface cdwi_res_if;
  logic               valid;
  logic               ready;
  logic [19:0]        row_number;
  logic               is_new;
  logic [19:0]        mapped_index;
  logic signed [31:0] batch_value;
  logic               batch_is_new;
  logic [10:0]        unique_count;
  logic [1:0]         status;
  logic               last_out;
  modport source (output valid, row_number, is_new, mapped_index, batch_value,
                  batch_is_new, unique_count, status, last_out, input ready);
  modport sink (input valid, row_number, is_new, mapped_index, batch_value,
                batch_is_new, unique_count, status, last_out, output ready);
endinterface

interface cdwi_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cdwi_pkg::CFG_IDX_W-1:0]   index;
  logic [cdwi_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/coordinate_dedup_with_inverse_unit.sv
// Channel  Role    Beat contents
// rows     sink    coord_a..coord_d, start_set, last_row
// results  source  row_number, is_new, mapped_index, batch_value, batch_is_new,
//                  unique_count, status, last_out
// cfg      sink    index, data (register write, always ready)
//
// One row is in flight at a time. After its beat, a row is prepared, then its
// hash folds one column per cycle over the n effective columns, the home slot
// is reduced modulo CAPACITY four bits per cycle, and each probe is one read
// of the table memories followed by a compare. A row whose batch value is out
// of range skips the lookup. A row with start_set first sweeps the valid and
// batch memories over max(CAPACITY, MAX_BATCH) addresses; the same sweep runs
// after reset, with rows held off. The result register lets a new row be taken
// while the previous result waits; a stalled result only blocks the finish of
// the next row.
module coordinate_dedup_with_inverse_unit #(
  parameter int MAX_COLS  = cdwi_pkg::DEF_MAX_COLS,
  parameter int CAPACITY  = cdwi_pkg::DEF_CAPACITY,
  parameter int MAX_ROWS  = cdwi_pkg::DEF_MAX_ROWS,
  parameter int MAX_BATCH = cdwi_pkg::DEF_MAX_BATCH
) (
  input logic       clk,
  input logic       rst,
  cdwi_row_if.sink  rows,
  cdwi_res_if.source results,
  cdwi_cfg_if.sink  cfg
);
  import cdwi_pkg::*;

  localparam int KEY_COLS = (MAX_COLS < IN_COLS) ? MAX_COLS : IN_COLS;
  localparam int AW       = $clog2(CAPACITY);
  localparam int UW       = $clog2(CAPACITY + 1);
  localparam int RW       = $clog2(MAX_ROWS);
  localparam int BW       = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int SWEEP    = (CAPACITY > MAX_BATCH) ? CAPACITY : MAX_BATCH;
  localparam int CW       = $clog2(SWEEP);
  localparam int KW       = KEY_COLS * 32;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_HASH  = 8'b0000_1000,
    S_MOD   = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Configuration registers.
  logic [2:0] num_cols;
  logic       batch_lead;
  logic       remap_new;
  logic       report_stored;

  state_t             state;
  logic [IN_COLS-1:0][31:0] col;
  logic               last_q;
  logic               pending;
  logic [CW-1:0]      clr;
  logic [31:0]        h;
  logic [1:0]         hidx;
  logic [2:0]         mcnt;
  logic [AW-1:0]      r;
  logic [AW-1:0]      slot;
  logic [AW-1:0]      probe;
  logic [UW-1:0]      uc;
  logic [RW-1:0]      rc;
  logic [RW-1:0]      row_q;
  logic               is_new_q;
  logic [19:0]        mapped_q;
  logic               bnew_q;
  status_t            status_q;

  // Table memories and their registered read data.
  logic [KW-1:0] key_mem [CAPACITY];
  logic [20:0]   val_mem [CAPACITY];
  logic          batch_mem [MAX_BATCH];
  logic [KW-1:0] key_rd;
  logic [20:0]   val_rd;
  logic          bseen;

  logic          val_we;
  logic [AW-1:0] val_waddr;
  logic [20:0]   val_wdata;
  logic          key_we;
  logic          bat_we;
  logic [BW-1:0] bat_waddr;
  logic          bat_wdata;

  logic [2:0]         n;
  logic [1:0]         bcol;
  logic signed [31:0] bval;
  logic               b_oor;
  logic [BW-1:0]      bidx;
  logic [31:0]        hstep;
  logic [AW-1:0]      modr_next;
  logic               match;
  logic [19:0]        assign_val;
  logic [AW:0]        slot_inc;

  // Effective column count and batch column.
  always_comb begin
    n = num_cols;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(KEY_COLS)) n = 3'(KEY_COLS);
    bcol = batch_lead ? 2'd0 : 2'(n - 3'd1);
    bval = $signed(col[bcol]);
    b_oor = (bval < 0) || (bval >= MAX_BATCH);
    bidx = BW'(col[bcol]);
  end

  assign hstep = 32'((h ^ col[hidx]) * FNV_PRIME);

  // Four steps of restoring reduction of the hash modulo CAPACITY.
  always_comb begin
    logic [AW:0] t;
    modr_next = r;
    for (int j = 0; j < 4; j++) begin
      t = {modr_next, h[31-j]};
      if (t >= (AW+1)'(CAPACITY)) t = t - (AW+1)'(CAPACITY);
      modr_next = t[AW-1:0];
    end
  end

  always_comb begin
    match = val_rd[20];
    for (int i = 0; i < KEY_COLS; i++) begin
      if ((3'(i) < n) && (key_rd[i*32 +: 32] != col[i])) match = 1'b0;
    end
  end

  assign assign_val = (report_stored || remap_new) ? 20'(uc) : 20'(row_q);
  assign slot_inc   = (AW+1)'(slot) + (AW+1)'(1);

  // Memory write control.
  always_comb begin
    val_we    = 1'b0;
    val_waddr = slot;
    val_wdata = {1'b1, assign_val};
    key_we    = 1'b0;
    bat_we    = 1'b0;
    bat_waddr = bidx;
    bat_wdata = 1'b1;
    if (state == S_CLEAR) begin
      val_we    = (CW'(clr) < CW'(CAPACITY - 1)) || (clr == CW'(CAPACITY - 1));
      val_waddr = AW'(clr);
      val_wdata = '0;
      bat_we    = (clr < CW'(MAX_BATCH - 1)) || (clr == CW'(MAX_BATCH - 1));
      bat_waddr = BW'(clr);
      bat_wdata = 1'b0;
    end else if ((state == S_CMP) && !val_rd[20]) begin
      val_we = 1'b1;
      key_we = 1'b1;
      bat_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot] <= col[KEY_COLS-1:0];
    key_rd <= key_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rd <= val_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (bat_we) batch_mem[bat_waddr] <= bat_wdata;
    bseen <= batch_mem[bidx];
  end

  assign rows.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols      <= 3'd4;
      batch_lead    <= 1'b0;
      remap_new     <= 1'b0;
      report_stored <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NUM_COLS:      num_cols      <= cfg.data[2:0];
        REG_BATCH_LEAD:    batch_lead    <= cfg.data[0];
        REG_REMAP_NEW:     remap_new     <= cfg.data[0];
        REG_REPORT_STORED: report_stored <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Row sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      pending <= 1'b0;
      clr     <= '0;
      uc      <= '0;
      rc      <= '0;
      results.valid <= 1'b0;
    end else begin
      // The done state loads the result register itself.
      if (results.valid && results.ready && (state != S_DONE)) results.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (rows.valid) begin
            col    <= {rows.coord_d, rows.coord_c, rows.coord_b, rows.coord_a};
            last_q <= rows.last_row;
            if (rows.start_set) begin
              clr     <= '0;
              uc      <= '0;
              rc      <= '0;
              pending <= 1'b1;
              state   <= S_CLEAR;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_CLEAR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(SWEEP - 1)) begin
            pending <= 1'b0;
            state   <= pending ? S_PREP : S_IDLE;
          end
        end
        S_PREP: begin
          row_q    <= rc;
          rc       <= ((RW+1)'(rc) + (RW+1)'(1) >= (RW+1)'(MAX_ROWS)) ? '0 : rc + RW'(1);
          is_new_q <= 1'b0;
          mapped_q <= '0;
          bnew_q   <= 1'b0;
          status_q <= ST_OK;
          h        <= FNV_BASIS;
          hidx     <= '0;
          if (b_oor) begin
            status_q <= ST_BATCH_OOR;
            state    <= S_DONE;
          end else begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          h    <= hstep;
          hidx <= hidx + 2'd1;
          if (3'(hidx) == n - 3'd1) begin
            r     <= '0;
            mcnt  <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          r    <= modr_next;
          h    <= {h[27:0], 4'd0};
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd7) begin
            slot  <= modr_next;
            probe <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (!val_rd[20]) begin
            is_new_q <= 1'b1;
            mapped_q <= assign_val;
            bnew_q   <= !bseen;
            uc       <= uc + UW'(1);
            state    <= S_DONE;
          end else if (match) begin
            mapped_q <= report_stored ? val_rd[19:0] : 20'd0;
            state    <= S_DONE;
          end else if (probe == AW'(CAPACITY - 1)) begin
            status_q <= ST_FULL;
            state    <= S_DONE;
          end else begin
            probe <= probe + AW'(1);
            slot  <= (slot_inc == (AW+1)'(CAPACITY)) ? '0 : slot_inc[AW-1:0];
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid        <= 1'b1;
            results.row_number   <= 20'(row_q);
            results.is_new       <= is_new_q;
            results.mapped_index <= mapped_q;
            results.batch_value  <= bval;
            results.batch_is_new <= bnew_q;
            results.unique_count <= 11'(uc);
            results.status       <= status_q;
            results.last_out     <= last_q;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/cdwi_checker.sv
module cdwi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_new,
  input logic [19:0] mapped_index,
  input logic        batch_is_new,
  input logic [1:0]  status
);
  import cdwi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_oor: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BATCH_OOR) |-> !is_new && !batch_is_new && mapped_index == 20'd0)
    else $error("out-of-range batch produced a lookup result");

  a_bnew: assert property (@(posedge clk) disable iff (rst)
    out_valid && batch_is_new |-> is_new)
    else $error("new batch reported without insertion");

  a_new_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> status == ST_OK)
    else $error("insertion reported with error status");

endmodule

bind coordinate_dedup_with_inverse_unit cdwi_checker u_cdwi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .is_new       (results.is_new),
  .mapped_index (results.mapped_index),
  .batch_is_new (results.batch_is_new),
  .status       (results.status)
);
